[rtl/sfr_pkg.sv]
`default_nettype none

package sfr_pkg;

	// frame store geometry
	localparam int BUF_BYTES = 64;
	localparam int ADDR_W    = $clog2(BUF_BYTES);
	localparam int CNT_W     = $clog2(BUF_BYTES + 1);

	// shortest frame that carries a header, one parameter and a crc
	localparam int MIN_FRAME = 11;

	// first parameter byte of a frame
	localparam int PARAM_FIRST = 8;

	localparam logic [15:0] CRC_POLY    = 16'h8005;
	localparam logic [15:0] CRC_INIT    = 16'h0000;
	localparam logic [15:0] TIMEOUT_RST = 16'd1002;

	// result queue in the back part, power of two so pointers wrap
	localparam int OUT_DEPTH = 4;
	localparam int OPTR_W    = $clog2(OUT_DEPTH);
	localparam int OCNT_W    = $clog2(OUT_DEPTH + 1);

	// request kinds
	localparam logic REQ_BYTE = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	// frame status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_LEN_ERR = 2'd1;
	localparam logic [1:0] ST_CRC_ERR = 2'd2;

	// frame job handed from front to back
	typedef struct packed {
		logic [CNT_W-1:0] n;
		logic [15:0]      crc;
	} cmd_t;

	// store write from the front part
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} wr_t;

	// what a store read is for
	typedef enum logic [2:0] {
		RT_ID,
		RT_LEN_LO,
		RT_LEN_HI,
		RT_INS,
		RT_CRC_LO,
		RT_CRC_HI,
		RT_PARAM
	} rtag_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_HDR,
		BK_PARAM
	} bk_state_t;

	typedef struct packed {
		logic [1:0]  frame_status;
		logic [7:0]  servo_id;
		logic [15:0] declared_length;
		logic [7:0]  instruction;
		logic [7:0]  param_byte;
		logic        param_valid;
		logic        last;
		logic [15:0] received_crc;
		logic [15:0] computed_crc;
		logic [6:0]  received_count;
	} result_t;

	// crc-16, msb first, one byte
	function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15])
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			else
				c = {c[14:0], 1'b0};
		end
		return c;
	endfunction

endpackage

`default_nettype wire

[rtl/sfr_front.sv]
`default_nettype none

module sfr_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire logic               store_busy,
	output logic                    full,
	input  wire logic               req_type,
	input  wire logic [7:0]         rx_byte,
	input  wire logic               cfg_we,
	input  wire logic [15:0]        cfg_data,
	output sfr_pkg::wr_t            wr,
	output logic                    cmd_push,
	output sfr_pkg::cmd_t           cmd
);

	logic [sfr_pkg::CNT_W-1:0] count_q;
	logic [15:0]               crc_q;
	logic [7:0]                older_q;
	logic [7:0]                newer_q;
	logic                      running_q;
	logic [15:0]               ticks_q;
	logic [15:0]               timeout_q;

	logic        accept;
	logic        is_byte;
	logic        store_en;
	logic        expire;
	logic [15:0] tick_inc;

	assign full   = store_busy;
	assign accept = push && !full;

	always_comb begin
		is_byte  = (req_type == sfr_pkg::REQ_BYTE);
		tick_inc = (ticks_q != 16'hFFFF) ? ticks_q + 16'd1 : ticks_q;
		store_en = accept && is_byte && (count_q < sfr_pkg::CNT_W'(sfr_pkg::BUF_BYTES));
		expire   = accept && !is_byte && running_q && (tick_inc >= timeout_q);
	end

	always_comb begin
		wr.en    = store_en;
		wr.addr  = count_q[sfr_pkg::ADDR_W-1:0];
		wr.data  = rx_byte;
		cmd_push = expire;
		cmd.n    = count_q;
		cmd.crc  = crc_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			crc_q     <= sfr_pkg::CRC_INIT;
			older_q   <= '0;
			newer_q   <= '0;
			running_q <= 1'b0;
			ticks_q   <= '0;
			timeout_q <= sfr_pkg::TIMEOUT_RST;
		end else begin
			if (cfg_we)
				timeout_q <= cfg_data;

			// gap timer
			if (accept && is_byte) begin
				running_q <= 1'b1;
				ticks_q   <= '0;
			end else if (accept && running_q) begin
				if (expire) begin
					running_q <= 1'b0;
					ticks_q   <= '0;
				end else begin
					ticks_q <= tick_inc;
				end
			end

			// crc runs two bytes behind the store
			if (store_en) begin
				if (count_q >= sfr_pkg::CNT_W'(2))
					crc_q <= sfr_pkg::crc_feed(crc_q, older_q);
				older_q <= newer_q;
				newer_q <= rx_byte;
				count_q <= count_q + sfr_pkg::CNT_W'(1);
			end else if (expire) begin
				count_q <= '0;
				crc_q   <= sfr_pkg::CRC_INIT;
				older_q <= '0;
				newer_q <= '0;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/sfr_cmdq.sv]
`default_nettype none

module sfr_cmdq (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  sfr_pkg::cmd_t      push_data,
	output logic               pop_valid,
	input  wire logic          pop,
	output sfr_pkg::cmd_t      pop_data
);

	sfr_pkg::cmd_t q_q [2];
	logic          wptr_q;
	logic          rptr_q;
	logic [1:0]    cnt_q;

	logic do_pop;

	assign pop_valid = (cnt_q != 2'd0);
	assign pop_data  = q_q[rptr_q];
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (push)
			q_q[wptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (push)
				wptr_q <= ~wptr_q;
			if (do_pop)
				rptr_q <= ~rptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, do_pop};
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (cnt_q < 2'd2 || do_pop))
		else $error("frame job queue overflow");

endmodule

`default_nettype wire

[rtl/sfr_back.sv]
`default_nettype none

module sfr_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  sfr_pkg::wr_t       wr,
	input  wire logic          cmd_valid,
	input  sfr_pkg::cmd_t      cmd,
	output logic               cmd_pop,
	output logic               busy,
	output logic               empty,
	input  wire logic          pop,
	output sfr_pkg::result_t   result
);

	logic [7:0] mem [sfr_pkg::BUF_BYTES];

	sfr_pkg::bk_state_t st_q, st_d;

	logic [sfr_pkg::CNT_W-1:0] n_q;
	logic [sfr_pkg::CNT_W-1:0] idx_q;
	logic [15:0]               ccrc_q;
	logic [7:0]                id_q;
	logic [15:0]               len_q;
	logic [7:0]                ins_q;
	logic [15:0]               rcrc_q;
	sfr_pkg::rtag_t            hdr_tag_q;

	logic                      rd_vld_s1;
	sfr_pkg::rtag_t            rd_tag_s1;
	logic                      rd_last_s1;
	logic [7:0]                rdata_s1;

	sfr_pkg::result_t          fifo_q [sfr_pkg::OUT_DEPTH];
	logic [sfr_pkg::OPTR_W-1:0] wptr_q;
	logic [sfr_pkg::OPTR_W-1:0] rptr_q;
	logic [sfr_pkg::OCNT_W-1:0] ocnt_q;

	logic                      rd_en;
	logic [sfr_pkg::ADDR_W-1:0] rd_addr;
	sfr_pkg::rtag_t            rd_tag;
	logic                      rd_last;
	logic                      start_ok;
	logic                      is_short;
	logic                      space;
	logic                      param_push;
	logic                      fifo_push;
	logic                      fifo_pop;
	sfr_pkg::result_t          push_res;
	logic [sfr_pkg::CNT_W-1:0] n_m2;
	logic [sfr_pkg::CNT_W-1:0] n_m1;
	logic [sfr_pkg::CNT_W-1:0] n_m3;

	always_comb begin
		n_m1  = n_q - sfr_pkg::CNT_W'(1);
		n_m2  = n_q - sfr_pkg::CNT_W'(2);
		n_m3  = n_q - sfr_pkg::CNT_W'(3);
		space = (ocnt_q + sfr_pkg::OCNT_W'(rd_vld_s1 && rd_tag_s1 == sfr_pkg::RT_PARAM))
			< sfr_pkg::OCNT_W'(sfr_pkg::OUT_DEPTH);
		start_ok = cmd_valid && !rd_vld_s1 && (ocnt_q < sfr_pkg::OCNT_W'(sfr_pkg::OUT_DEPTH));
		is_short = cmd.n < sfr_pkg::CNT_W'(sfr_pkg::MIN_FRAME);
	end

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			sfr_pkg::BK_IDLE: begin
				if (start_ok && !is_short)
					st_d = sfr_pkg::BK_HDR;
			end
			sfr_pkg::BK_HDR: begin
				if (hdr_tag_q == sfr_pkg::RT_CRC_HI)
					st_d = sfr_pkg::BK_PARAM;
			end
			sfr_pkg::BK_PARAM: begin
				if (space && idx_q == n_m3)
					st_d = sfr_pkg::BK_IDLE;
			end
			default: st_d = sfr_pkg::BK_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		cmd_pop = 1'b0;
		rd_en   = 1'b0;
		rd_tag  = sfr_pkg::RT_PARAM;
		rd_last = 1'b0;
		rd_addr = idx_q[sfr_pkg::ADDR_W-1:0];
		unique case (st_q)
			sfr_pkg::BK_IDLE: begin
				cmd_pop = start_ok;
			end
			sfr_pkg::BK_HDR: begin
				rd_en  = 1'b1;
				rd_tag = hdr_tag_q;
				unique case (hdr_tag_q)
					sfr_pkg::RT_ID:     rd_addr = sfr_pkg::ADDR_W'(4);
					sfr_pkg::RT_LEN_LO: rd_addr = sfr_pkg::ADDR_W'(5);
					sfr_pkg::RT_LEN_HI: rd_addr = sfr_pkg::ADDR_W'(6);
					sfr_pkg::RT_INS:    rd_addr = sfr_pkg::ADDR_W'(7);
					sfr_pkg::RT_CRC_LO: rd_addr = n_m2[sfr_pkg::ADDR_W-1:0];
					sfr_pkg::RT_CRC_HI: rd_addr = n_m1[sfr_pkg::ADDR_W-1:0];
					default:            rd_addr = idx_q[sfr_pkg::ADDR_W-1:0];
				endcase
			end
			sfr_pkg::BK_PARAM: begin
				rd_en   = space;
				rd_last = (idx_q == n_m3);
			end
			default: cmd_pop = 1'b0;
		endcase
	end

	assign busy = (st_q != sfr_pkg::BK_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= sfr_pkg::BK_IDLE;
			rd_vld_s1 <= 1'b0;
		end else begin
			st_q      <= st_d;
			rd_vld_s1 <= rd_en;
		end
	end

	// frame store, one write and one registered read port
	always_ff @(posedge clk) begin
		if (wr.en)
			mem[wr.addr] <= wr.data;
		if (rd_en)
			rdata_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		rd_tag_s1  <= rd_tag;
		rd_last_s1 <= rd_last;
		if (cmd_pop) begin
			n_q       <= cmd.n;
			ccrc_q    <= cmd.crc;
			hdr_tag_q <= sfr_pkg::RT_ID;
			idx_q     <= sfr_pkg::CNT_W'(sfr_pkg::PARAM_FIRST);
		end
		if (st_q == sfr_pkg::BK_HDR && hdr_tag_q != sfr_pkg::RT_CRC_HI)
			hdr_tag_q <= sfr_pkg::rtag_t'(hdr_tag_q + 3'd1);
		if (st_q == sfr_pkg::BK_PARAM && rd_en)
			idx_q <= idx_q + sfr_pkg::CNT_W'(1);
		if (rd_vld_s1) begin
			case (rd_tag_s1)
				sfr_pkg::RT_ID:     id_q         <= rdata_s1;
				sfr_pkg::RT_LEN_LO: len_q[7:0]   <= rdata_s1;
				sfr_pkg::RT_LEN_HI: len_q[15:8]  <= rdata_s1;
				sfr_pkg::RT_INS:    ins_q        <= rdata_s1;
				sfr_pkg::RT_CRC_LO: rcrc_q[7:0]  <= rdata_s1;
				sfr_pkg::RT_CRC_HI: rcrc_q[15:8] <= rdata_s1;
				default:            ;
			endcase
		end
	end

	// result assembly
	always_comb begin
		param_push = rd_vld_s1 && (rd_tag_s1 == sfr_pkg::RT_PARAM);
		fifo_push  = param_push || (cmd_pop && is_short);
		fifo_pop   = pop && !empty;
		push_res   = '0;
		if (param_push) begin
			push_res.frame_status    = (rcrc_q == ccrc_q) ? sfr_pkg::ST_OK : sfr_pkg::ST_CRC_ERR;
			push_res.servo_id        = id_q;
			push_res.declared_length = len_q;
			push_res.instruction     = ins_q;
			push_res.param_byte      = rdata_s1;
			push_res.param_valid     = 1'b1;
			push_res.last            = rd_last_s1;
			push_res.received_crc    = rcrc_q;
			push_res.computed_crc    = ccrc_q;
			push_res.received_count  = 7'(n_q);
		end else begin
			push_res.frame_status   = sfr_pkg::ST_LEN_ERR;
			push_res.last           = 1'b1;
			push_res.received_count = 7'(cmd.n);
		end
	end

	always_ff @(posedge clk) begin
		if (fifo_push)
			fifo_q[wptr_q] <= push_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			ocnt_q <= '0;
		end else begin
			if (fifo_push)
				wptr_q <= wptr_q + sfr_pkg::OPTR_W'(1);
			if (fifo_pop)
				rptr_q <= rptr_q + sfr_pkg::OPTR_W'(1);
			ocnt_q <= ocnt_q + sfr_pkg::OCNT_W'(fifo_push) - sfr_pkg::OCNT_W'(fifo_pop);
		end
	end

	assign empty  = (ocnt_q == '0);
	assign result = fifo_q[rptr_q];

	a_store_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> st_q == sfr_pkg::BK_IDLE)
		else $error("frame store written while a frame is read out");

	a_result_room: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_push |-> ocnt_q < sfr_pkg::OCNT_W'(sfr_pkg::OUT_DEPTH))
		else $error("result queue overflow");

	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_vld_s1 && rd_tag_s1 == sfr_pkg::RT_PARAM && rd_last_s1) |-> st_q == sfr_pkg::BK_IDLE)
		else $error("sequencer still busy after last parameter read");

endmodule

`default_nettype wire

[rtl/status_frame_receiver.sv]
`default_nettype none

// status frame receiver: push one request per cycle, either a received serial byte
// (req_type 0) or a one-microsecond tick (req_type 1). bytes go into a 64-byte frame
// store (extra bytes are dropped but still restart the gap timer) while a crc-16
// (poly 0x8005, seed 0, msb first) runs two bytes behind. once gap_timeout_us ticks
// pass without a byte, the frame is closed: a frame shorter than 11 bytes gives a
// single length-error result; otherwise one result per parameter byte (bytes 8 to
// count-3), each carrying id, declared length, instruction, both crcs and the status,
// with last set on the final one. while the store is free a request is taken every
// cycle. after the closing tick, full stays high until the back end has read the
// frame out of its single store read port: it picks up the job, makes six header
// reads, then one read per parameter byte; the parameter reads pause while the
// four-entry result queue is full, and a short frame only needs its job picked up.
// gap_timeout_us is written over cfg_valid/cfg_ready (always ready); write it only
// while the block is idle, the block itself does not enforce this; reset value 1002.

module status_frame_receiver (
	input  wire logic        clk,
	input  wire logic        arst_n,

	// request side
	input  wire logic        push,
	output logic             full,
	input  wire logic        req_type,
	input  wire logic [7:0]  rx_byte,

	// result side
	output logic             empty,
	input  wire logic        pop,
	output logic [1:0]       frame_status,
	output logic [7:0]       servo_id,
	output logic [15:0]      declared_length,
	output logic [7:0]       instruction,
	output logic [7:0]       param_byte,
	output logic             param_valid,
	output logic             last,
	output logic [15:0]      received_crc,
	output logic [15:0]      computed_crc,
	output logic [6:0]       received_count,

	// gap timeout register
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] gap_timeout_us
);

	// front to queue to back
	sfr_pkg::wr_t     wr;
	logic             cmd_push;
	sfr_pkg::cmd_t    cmd_in;
	logic             cmd_valid;
	logic             cmd_pop;
	sfr_pkg::cmd_t    cmd_out;

	// store is in use from frame close until the back end finished its reads
	logic             back_busy;
	logic             store_busy;

	sfr_pkg::result_t res;

	assign cfg_ready  = 1'b1;
	assign store_busy = cmd_valid || back_busy;

	// byte collection, crc and gap timer
	sfr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.store_busy (store_busy),
		.full       (full),
		.req_type   (req_type),
		.rx_byte    (rx_byte),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_data   (gap_timeout_us),
		.wr         (wr),
		.cmd_push   (cmd_push),
		.cmd        (cmd_in)
	);

	// closed frames waiting for the back end
	sfr_cmdq u_cmdq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cmd_push),
		.push_data (cmd_in),
		.pop_valid (cmd_valid),
		.pop       (cmd_pop),
		.pop_data  (cmd_out)
	);

	// frame store, header and parameter readout, result queue
	sfr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (wr),
		.cmd_valid (cmd_valid),
		.cmd       (cmd_out),
		.cmd_pop   (cmd_pop),
		.busy      (back_busy),
		.empty     (empty),
		.pop       (pop),
		.result    (res)
	);

	// oldest result straight from the queue head
	assign frame_status    = res.frame_status;
	assign servo_id        = res.servo_id;
	assign declared_length = res.declared_length;
	assign instruction     = res.instruction;
	assign param_byte      = res.param_byte;
	assign param_valid     = res.param_valid;
	assign last            = res.last;
	assign received_crc    = res.received_crc;
	assign computed_crc    = res.computed_crc;
	assign received_count  = res.received_count;

endmodule

`default_nettype wire
